>>> rtl/torus_point_depth_shader_defines.svh
// ----------------------------------------------------------------------------
// Torus point depth shader assertion macros
// Shared property wrappers for the shader's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef TORUS_POINT_DEPTH_SHADER_DEFINES_SVH
`define TORUS_POINT_DEPTH_SHADER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define TPDS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("shader assertion failed");

// Check that cons holds in the cycle after ante.
`define TPDS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("shader assertion failed");

`endif

>>> rtl/tpds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Torus point depth shader package
// Shared types, widths, codes and constant tables.
// ----------------------------------------------------------------------------
package tpds_pkg;

    localparam int GRID_COLS     = 128;
    localparam int GRID_ROWS     = 64;
    localparam int DEPTH_CELLS   = GRID_COLS * GRID_ROWS;
    localparam int ADDR_W        = $clog2(DEPTH_CELLS);
    localparam int PX_W          = 7;
    localparam int PY_W          = 6;
    localparam int TRIG_W        = 16;
    localparam int LEN_W         = 16;
    localparam int DEPTH_W       = 24;
    localparam int VAR_W         = 26;
    localparam int MUL_B_W       = 17;
    localparam int PROD_W        = VAR_W + MUL_B_W;
    localparam int FRAC_W        = 14;
    localparam int DEN_W         = 23;
    localparam int DIV_D_W       = DEN_W + 8;
    localparam int DIV_N_W       = PROD_W;
    localparam int DIV_Q_W       = DIV_N_W + 1;
    localparam int N_STEPS       = 20;
    localparam int STEP_W        = $clog2(N_STEPS);
    localparam int GLYPH_LAST    = 11;

    localparam logic signed [DEPTH_W-1:0] DEPTH_EMPTY = {1'b1, {(DEPTH_W-1){1'b0}}};

    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_POINT = 1'b1;

    typedef enum logic [1:0] {
        REG_TUBE_RADIUS,
        REG_RING_RADIUS,
        REG_SCREEN_SCALE,
        REG_OBJECT_OFFSET
    } t_reg_idx;

    typedef struct packed {
        logic                     op;
        logic signed [TRIG_W-1:0] rot_sin_d;
        logic signed [TRIG_W-1:0] rot_cos_d;
        logic signed [TRIG_W-1:0] rot_sin_a;
        logic signed [TRIG_W-1:0] rot_cos_a;
        logic signed [TRIG_W-1:0] pt_sin_psi;
        logic signed [TRIG_W-1:0] pt_cos_psi;
        logic signed [TRIG_W-1:0] pt_sin_theta;
        logic signed [TRIG_W-1:0] pt_cos_theta;
    } t_in_item;

    typedef struct packed {
        logic [PX_W-1:0] pixel_x;
        logic [PY_W-1:0] pixel_y;
        logic [7:0]      glyph;
    } t_out_item;

    // Classified command: frame carries sd,cd,sa,ca; point carries sp,cp,st,ct.
    typedef struct packed {
        logic                     is_frame;
        logic signed [TRIG_W-1:0] t0;
        logic signed [TRIG_W-1:0] t1;
        logic signed [TRIG_W-1:0] t2;
        logic signed [TRIG_W-1:0] t3;
    } t_cmd;

    typedef struct packed {
        logic [LEN_W-1:0] tube_radius;
        logic [LEN_W-1:0] ring_radius;
        logic [LEN_W-1:0] screen_scale;
        logic [LEN_W-1:0] object_offset;
    } t_cfg;

    typedef struct packed {
        logic init;
        logic busy;
    } t_back_stat;

    typedef enum logic [4:0] {
        V_ZERO, V_TUBE, V_RING, V_CT, V_ST, V_C, V_S, V_U, V_T1, V_W,
        V_NU, V_NT1, V_NW, V_N0, V_Z, V_X, V_Y, V_LUMI
    } t_var;

    typedef enum logic [2:0] {
        T_SD, T_CD, T_SA, T_CA, T_SP, T_CP, T_ST, T_CT
    } t_trig;

    // dst = base +/- floor(a * b / 2^14)
    typedef struct packed {
        t_var  a;
        t_trig b;
        t_var  base;
        t_var  dst;
        logic  sub;
    } t_step;

    function automatic t_step step_rom(input logic [STEP_W-1:0] idx);
        t_step s;
        unique case (idx)
            5'd0:    s = '{V_TUBE, T_CT, V_RING, V_C,    1'b0};
            5'd1:    s = '{V_TUBE, T_ST, V_ZERO, V_S,    1'b0};
            5'd2:    s = '{V_C,    T_CP, V_ZERO, V_U,    1'b0};
            5'd3:    s = '{V_U,    T_SD, V_ZERO, V_T1,   1'b0};
            5'd4:    s = '{V_S,    T_CD, V_T1,   V_T1,   1'b0};
            5'd5:    s = '{V_C,    T_SP, V_ZERO, V_W,    1'b0};
            5'd6:    s = '{V_T1,   T_CA, V_ZERO, V_Z,    1'b0};
            5'd7:    s = '{V_W,    T_SA, V_Z,    V_Z,    1'b0};
            5'd8:    s = '{V_U,    T_CD, V_ZERO, V_X,    1'b0};
            5'd9:    s = '{V_S,    T_SD, V_X,    V_X,    1'b1};
            5'd10:   s = '{V_T1,   T_SA, V_ZERO, V_Y,    1'b0};
            5'd11:   s = '{V_W,    T_CA, V_Y,    V_Y,    1'b1};
            5'd12:   s = '{V_CT,   T_CP, V_ZERO, V_NU,   1'b0};
            5'd13:   s = '{V_NU,   T_SD, V_ZERO, V_NT1,  1'b0};
            5'd14:   s = '{V_ST,   T_CD, V_NT1,  V_NT1,  1'b0};
            5'd15:   s = '{V_CT,   T_SP, V_ZERO, V_NW,   1'b0};
            5'd16:   s = '{V_NU,   T_CD, V_ZERO, V_N0,   1'b0};
            5'd17:   s = '{V_ST,   T_SD, V_N0,   V_N0,   1'b1};
            5'd18:   s = '{V_NT1,  T_CA, V_N0,   V_LUMI, 1'b0};
            5'd19:   s = '{V_NW,   T_SA, V_LUMI, V_LUMI, 1'b0};
            default: s = '{V_ZERO, T_SD, V_ZERO, V_ZERO, 1'b0};
        endcase
        return s;
    endfunction

    function automatic logic [7:0] glyph_rom(input logic [3:0] idx);
        logic [7:0] g;
        unique case (idx)
            4'd0:    g = 8'h2E; // .
            4'd1:    g = 8'h2C; // ,
            4'd2:    g = 8'h2D; // -
            4'd3:    g = 8'h7E; // ~
            4'd4:    g = 8'h3A; // :
            4'd5:    g = 8'h3B; // ;
            4'd6:    g = 8'h3D; // =
            4'd7:    g = 8'h21; // !
            4'd8:    g = 8'h2A; // *
            4'd9:    g = 8'h23; // #
            4'd10:   g = 8'h24; // $
            default: g = 8'h40; // @
        endcase
        return g;
    endfunction

endpackage

>>> rtl/tpds_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Torus point depth shader front end
// Accepts input transactions, sorts them into commands, queues them.
// ----------------------------------------------------------------------------
module tpds_front import tpds_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_data,
    output logic     o_in_stall,
    input  logic     i_hold,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_pop
);

    localparam int Q_DEPTH = 2;
    localparam int PTR_W   = $clog2(Q_DEPTH);
    localparam int CNT_W   = $clog2(Q_DEPTH + 1);

    t_cmd             r_q [Q_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;
    t_cmd             cmd;

    assign o_in_stall  = (r_count == CNT_W'(Q_DEPTH)) || i_hold;
    assign push        = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_count != '0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rd];

    // Keep only the trig that the command needs.
    always_comb begin
        cmd.is_frame = (i_in_data.op == OP_FRAME);
        if (cmd.is_frame) begin
            cmd.t0 = i_in_data.rot_sin_d;
            cmd.t1 = i_in_data.rot_cos_d;
            cmd.t2 = i_in_data.rot_sin_a;
            cmd.t3 = i_in_data.rot_cos_a;
        end else begin
            cmd.t0 = i_in_data.pt_sin_psi;
            cmd.t1 = i_in_data.pt_cos_psi;
            cmd.t2 = i_in_data.pt_sin_theta;
            cmd.t3 = i_in_data.pt_cos_theta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cmd;
        end
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/tpds_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Torus point depth shader divider
// Serial restoring divider, one quotient bit per cycle, floor rounding.
// ----------------------------------------------------------------------------
module tpds_div import tpds_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [DIV_N_W-1:0] i_num,
    input  logic        [DIV_D_W-1:0] i_den,
    output logic                      o_done,
    output logic signed [DIV_Q_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(DIV_N_W + 1);

    logic [DIV_N_W-1:0] r_mag;
    logic [DIV_N_W-1:0] r_q;
    logic [DIV_D_W-1:0] r_rem;
    logic [DIV_D_W-1:0] r_den;
    logic               r_neg;
    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [DIV_D_W:0]   rem_sh;
    logic               ge;
    logic [DIV_D_W:0]   rem_nx;
    logic signed [DIV_Q_W-1:0] q_pos;

    assign rem_sh = {r_rem, r_mag[DIV_N_W-1]};
    assign ge     = (rem_sh >= {1'b0, r_den});
    assign rem_nx = ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
    assign q_pos  = signed'({1'b0, r_q});
    // Round toward minus infinity for a negative numerator.
    assign o_quot = r_neg ? -(q_pos + DIV_Q_W'(r_rem != '0)) : q_pos;
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[DIV_N_W-1];
            r_mag <= i_num[DIV_N_W-1] ? DIV_N_W'(-i_num) : DIV_N_W'(i_num);
            r_q   <= '0;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_mag <= {r_mag[DIV_N_W-2:0], 1'b0};
            r_q   <= {r_q[DIV_N_W-2:0], ge};
            r_rem <= rem_nx[DIV_D_W-1:0];
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_N_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

>>> rtl/tpds_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Torus point depth shader back end
// Runs the transform on a shared multiplier, divides, depth tests, emits.
// ----------------------------------------------------------------------------
module tpds_back import tpds_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    output t_back_stat o_stat,
    output logic       o_out_valid,
    output t_out_item  o_out_data,
    input  logic       i_out_stall
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MUL, S_ACC, S_DEN, S_DIVX, S_WAITX,
        S_DIVY, S_WAITY, S_RANGE, S_RD, S_CMP, S_OUT
    } t_state;

    t_state r_state;
    logic   r_init;
    logic [STEP_W-1:0] r_step;
    logic [ADDR_W-1:0] r_addr;

    logic signed [TRIG_W-1:0] r_sd, r_cd, r_sa, r_ca, r_sp, r_cp, r_st, r_ct;
    logic signed [VAR_W-1:0]  r_c, r_s, r_u, r_t1, r_w, r_nu, r_nt1, r_nw, r_n0;
    logic signed [VAR_W-1:0]  r_z, r_x, r_y, r_lumi;
    logic signed [PROD_W-1:0] r_prod;
    logic        [DEN_W-1:0]  r_den;
    logic signed [DIV_Q_W-1:0] r_qx;
    logic        [PX_W-1:0]   r_px;
    logic        [PY_W-1:0]   r_py;
    logic signed [DEPTH_W-1:0] r_rd;
    logic        r_out_valid;
    t_out_item   r_out;

    logic signed [DEPTH_W-1:0] mem [DEPTH_CELLS];

    t_step                     step;
    logic signed [VAR_W-1:0]   a_val;
    logic signed [VAR_W-1:0]   base_val;
    logic signed [TRIG_W-1:0]  b_val;
    logic signed [VAR_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic                      prod_en;
    logic signed [VAR_W-1:0]   m_val;
    logic signed [VAR_W-1:0]   acc_val;
    logic signed [VAR_W:0]     den_full;
    logic                      div_start;
    logic                      div_done;
    logic signed [DIV_Q_W-1:0] div_quot;
    logic signed [DIV_Q_W:0]   px_full;
    logic signed [DIV_Q_W:0]   py_full;
    logic                      on_canvas;
    logic                      nearer;
    logic                      mem_we;
    logic signed [DEPTH_W-1:0] mem_wdata;
    logic [VAR_W+3:0]          lumi13;
    logic [VAR_W+3:0]          gi_wide;
    logic [3:0]                gi;
    logic                      out_free;

    assign step = step_rom(r_step);

    always_comb begin
        case (step.a)
            V_TUBE:  a_val = VAR_W'(signed'({1'b0, i_cfg.tube_radius}));
            V_CT:    a_val = VAR_W'(r_ct);
            V_ST:    a_val = VAR_W'(r_st);
            V_C:     a_val = r_c;
            V_S:     a_val = r_s;
            V_U:     a_val = r_u;
            V_T1:    a_val = r_t1;
            V_W:     a_val = r_w;
            V_NU:    a_val = r_nu;
            V_NT1:   a_val = r_nt1;
            V_NW:    a_val = r_nw;
            default: a_val = '0;
        endcase
        case (step.base)
            V_RING:  base_val = VAR_W'(signed'({1'b0, i_cfg.ring_radius}));
            V_T1:    base_val = r_t1;
            V_Z:     base_val = r_z;
            V_X:     base_val = r_x;
            V_Y:     base_val = r_y;
            V_NT1:   base_val = r_nt1;
            V_N0:    base_val = r_n0;
            V_LUMI:  base_val = r_lumi;
            default: base_val = '0;
        endcase
        case (step.b)
            T_SD:    b_val = r_sd;
            T_CD:    b_val = r_cd;
            T_SA:    b_val = r_sa;
            T_CA:    b_val = r_ca;
            T_SP:    b_val = r_sp;
            T_CP:    b_val = r_cp;
            T_ST:    b_val = r_st;
            default: b_val = r_ct;
        endcase
    end

    // Shared multiplier operands: transform steps, then the two numerators.
    always_comb begin
        prod_en = 1'b1;
        case (r_state)
            S_MUL: begin
                mul_a = a_val;
                mul_b = MUL_B_W'(b_val);
            end
            S_DEN: begin
                mul_a = r_x;
                mul_b = signed'({1'b0, i_cfg.screen_scale});
            end
            S_DIVX: begin
                mul_a = r_y;
                mul_b = signed'({1'b0, i_cfg.screen_scale});
            end
            default: begin
                mul_a   = '0;
                mul_b   = '0;
                prod_en = 1'b0;
            end
        endcase
    end

    assign m_val   = VAR_W'(r_prod >>> FRAC_W);
    assign acc_val = step.sub ? (base_val - m_val) : (base_val + m_val);
    assign den_full = signed'({1'b0, i_cfg.object_offset}) - (VAR_W + 1)'(r_z);

    assign div_start = (r_state == S_DIVX) || (r_state == S_DIVY);

    tpds_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_prod),
        .i_den   ({r_den, 8'h00}),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign px_full   = (DIV_Q_W + 1)'(r_qx) + (DIV_Q_W + 1)'(GRID_COLS / 2);
    assign py_full   = (DIV_Q_W + 1)'(div_quot) + (DIV_Q_W + 1)'(GRID_ROWS / 2);
    assign on_canvas = (px_full >= 0) && (px_full < GRID_COLS) &&
                       (py_full >= 0) && (py_full < GRID_ROWS);

    assign nearer    = (signed'(r_z[DEPTH_W-1:0]) > r_rd);
    assign mem_we    = (r_state == S_CLEAR) || ((r_state == S_CMP) && nearer);
    assign mem_wdata = (r_state == S_CLEAR) ? DEPTH_EMPTY : r_z[DEPTH_W-1:0];

    // Lambert ramp: index = lumi * 6.5, saturated.
    assign lumi13  = (VAR_W + 4)'(unsigned'(r_lumi)) * (VAR_W + 4)'(13);
    assign gi_wide = lumi13 >> 15;
    always_comb begin
        if (r_lumi < 0) begin
            gi = 4'd0;
        end else if (gi_wide > (VAR_W + 4)'(GLYPH_LAST)) begin
            gi = 4'(GLYPH_LAST);
        end else begin
            gi = gi_wide[3:0];
        end
    end

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_cmd_pop   = (r_state == S_IDLE) && i_cmd_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_stat.init = r_init;
    assign o_stat.busy = (r_state != S_IDLE) && (r_state != S_CLEAR);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_addr] <= mem_wdata;
        end
        r_rd <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (prod_en) begin
            r_prod <= mul_a * mul_b;
        end
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_init      <= 1'b1;
            r_addr      <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_sd        <= '0;
            r_cd        <= '0;
            r_sa        <= '0;
            r_ca        <= '0;
        end else begin
            // Load the output register only once it is free; hold it while stalled.
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid   <= 1'b1;
                r_out.pixel_x <= r_px;
                r_out.pixel_y <= r_py;
                r_out.glyph   <= glyph_rom(gi);
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == ADDR_W'(DEPTH_CELLS - 1)) begin
                        r_init  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        if (i_cmd.is_frame) begin
                            r_sd    <= i_cmd.t0;
                            r_cd    <= i_cmd.t1;
                            r_sa    <= i_cmd.t2;
                            r_ca    <= i_cmd.t3;
                            r_addr  <= '0;
                            r_state <= S_CLEAR;
                        end else begin
                            r_sp    <= i_cmd.t0;
                            r_cp    <= i_cmd.t1;
                            r_st    <= i_cmd.t2;
                            r_ct    <= i_cmd.t3;
                            r_step  <= '0;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    case (step.dst)
                        V_C:     r_c    <= acc_val;
                        V_S:     r_s    <= acc_val;
                        V_U:     r_u    <= acc_val;
                        V_T1:    r_t1   <= acc_val;
                        V_W:     r_w    <= acc_val;
                        V_Z:     r_z    <= acc_val;
                        V_X:     r_x    <= acc_val;
                        V_Y:     r_y    <= acc_val;
                        V_NU:    r_nu   <= acc_val;
                        V_NT1:   r_nt1  <= acc_val;
                        V_NW:    r_nw   <= acc_val;
                        V_N0:    r_n0   <= acc_val;
                        V_LUMI:  r_lumi <= acc_val;
                        default: ;
                    endcase
                    if (r_step == STEP_W'(N_STEPS - 1)) begin
                        r_state <= S_DEN;
                    end else begin
                        r_step  <= r_step + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_DEN: begin
                    // Drop a point at or behind the viewer.
                    r_den <= den_full[DEN_W-1:0];
                    r_state <= (den_full > 0) ? S_DIVX : S_IDLE;
                end
                S_DIVX: begin
                    r_state <= S_WAITX;
                end
                S_WAITX: begin
                    if (div_done) begin
                        r_qx    <= div_quot;
                        r_state <= S_DIVY;
                    end
                end
                S_DIVY: begin
                    r_state <= S_WAITY;
                end
                S_WAITY: begin
                    if (div_done) begin
                        r_state <= on_canvas ? S_RANGE : S_IDLE;
                        r_px    <= px_full[PX_W-1:0];
                        r_py    <= py_full[PY_W-1:0];
                    end
                end
                S_RANGE: begin
                    r_addr  <= ADDR_W'(r_py) * ADDR_W'(GRID_COLS) + ADDR_W'(r_px);
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_state <= nearer ? S_OUT : S_IDLE;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/torus_point_depth_shader.sv
`timescale 1ns / 1ps
`include "torus_point_depth_shader_defines.svh"
// ----------------------------------------------------------------------------
// Torus point depth shader
// Rotates, projects and depth tests torus surface samples into a glyph canvas.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data): op 0 starts a frame
//   with the rotation trig and wipes the depth store; op 1 is one surface
//   point. A transaction is taken when valid is high and stall is low.
//   Output channel (o_out_valid / i_out_stall / o_out_data): one transaction
//   per visible, nearer point with pixel column, row and glyph byte.
//   APB port: tube radius, ring radius, screen scale, object offset at byte
//   addresses 0, 4, 8, 12. Write only while the block is idle.
//   Processing: a point takes a pop, 20 multiply steps on one shared
//   multiplier, a divisor step, two serial divides (start, bit steps,
//   done), then address, read, compare and output steps before the
//   output register is loaded. The back end works on one point at a
//   time; the next is popped only after the last one is done. A new
//   frame holds the back end while the depth memory is swept.
//   Reset: the depth memory is swept to empty while o_in_stall stays
//   high; configuration writes are taken throughout.
//   A stalled output holds its transaction; the two-entry command queue
//   keeps accepting input until it fills.
// ----------------------------------------------------------------------------
module torus_point_depth_shader
    import tpds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_in_item    i_in_data,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output t_out_item   o_out_data,
    input  logic        i_out_stall,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg       r_cfg;
    t_reg_idx   reg_idx;
    logic       cfg_wr;
    logic       cmd_valid;
    t_cmd       cmd;
    logic       cmd_pop;
    t_back_stat stat;

    // Register file: one 16-bit value per word.
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_idx)
            REG_TUBE_RADIUS:   prdata = {16'h0000, r_cfg.tube_radius};
            REG_RING_RADIUS:   prdata = {16'h0000, r_cfg.ring_radius};
            REG_SCREEN_SCALE:  prdata = {16'h0000, r_cfg.screen_scale};
            REG_OBJECT_OFFSET: prdata = {16'h0000, r_cfg.object_offset};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tube_radius   <= 16'd256;
            r_cfg.ring_radius   <= 16'd512;
            r_cfg.screen_scale  <= 16'd20480;
            r_cfg.object_offset <= 16'd1280;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_TUBE_RADIUS:   r_cfg.tube_radius   <= pwdata[15:0];
                REG_RING_RADIUS:   r_cfg.ring_radius   <= pwdata[15:0];
                REG_SCREEN_SCALE:  r_cfg.screen_scale  <= pwdata[15:0];
                REG_OBJECT_OFFSET: r_cfg.object_offset <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Front end: accept and sort transactions; hold off during the reset sweep.
    tpds_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_hold      (stat.init),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // Back end: transform, divide, depth test, output register.
    tpds_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    // Block input for the whole reset sweep.
    `TPDS_ASSERT_NOW(a_init_stalls, stat.init, o_in_stall)
    // No result can exist before the depth memory is swept.
    `TPDS_ASSERT_NOW(a_init_no_out, stat.init, !o_out_valid)
    // A new result comes only from a point that the back end was working on.
    `TPDS_ASSERT_NOW(a_out_from_work, $rose(o_out_valid), $past(stat.busy))

endmodule

>>> tb/torus_point_depth_shader_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Torus point depth shader checker
// Watches the input, output and register ports. It predicts each pixel
// transaction from its own copy of the rotation, the depth store and the
// registers, then compares every output transaction in order.
// ----------------------------------------------------------------------------
module torus_point_depth_shader_checker
    import tpds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_item    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_item   i_out_data,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_count,
    output int          o_pending
);

    localparam string GLYPH_RAMP = ".,-~:;=!*#$@";

    logic [LEN_W-1:0] tube_r, ring_r, scr_scale, obj_off;
    longint           rot_sd, rot_cd, rot_sa, rot_ca;
    longint           depth_mem [DEPTH_CELLS];
    t_out_item        pixel_q [$];

    function automatic longint floor_quot(longint n, longint d);
        if (n >= 0) return n / d;
        return -((-n + d - 1) / d);
    endfunction

    function automatic longint trig_scale(longint v, longint t);
        return floor_quot(v * t, 64'sd16384);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    // Rotate, project, depth test and shade one surface point.
    task automatic shade_point(t_in_item it);
        longint sp, cp, st, ct, c, s, u, t1, w, z, x, y, den, px, py;
        longint nu, nt1, nw, n0, n2, lumi, gi;
        int slot;
        t_out_item pix;
        sp = it.pt_sin_psi;   cp = it.pt_cos_psi;
        st = it.pt_sin_theta; ct = it.pt_cos_theta;
        c  = longint'(ring_r) + trig_scale(longint'(tube_r), ct);
        s  = trig_scale(longint'(tube_r), st);
        u  = trig_scale(c, cp);
        t1 = trig_scale(u, rot_sd) + trig_scale(s, rot_cd);
        w  = trig_scale(c, sp);
        z  = trig_scale(t1, rot_ca) + trig_scale(w, rot_sa);
        x  = trig_scale(u, rot_cd) - trig_scale(s, rot_sd);
        y  = trig_scale(t1, rot_sa) - trig_scale(w, rot_ca);
        den = longint'(obj_off) - z;
        if (den <= 0) return;
        px = floor_quot(x * longint'(scr_scale), den * 256) + GRID_COLS / 2;
        py = floor_quot(y * longint'(scr_scale), den * 256) + GRID_ROWS / 2;
        if (px < 0 || px >= GRID_COLS || py < 0 || py >= GRID_ROWS) return;
        slot = int'(py * GRID_COLS + px);
        if (z <= depth_mem[slot]) return;
        depth_mem[slot] = z;
        nu   = trig_scale(ct, cp);
        nt1  = trig_scale(nu, rot_sd) + trig_scale(st, rot_cd);
        nw   = trig_scale(ct, sp);
        n0   = trig_scale(nu, rot_cd) - trig_scale(st, rot_sd);
        n2   = trig_scale(nt1, rot_ca) + trig_scale(nw, rot_sa);
        lumi = n0 + n2;
        if (lumi < 0) gi = 0;
        else begin
            gi = (lumi * 13) / 32768;
            if (gi > GLYPH_LAST) gi = GLYPH_LAST;
        end
        pix.pixel_x = px[PX_W-1:0];
        pix.pixel_y = py[PY_W-1:0];
        pix.glyph   = GLYPH_RAMP[gi];
        pixel_q.push_back(pix);
    endtask

    task automatic clear_depth();
        foreach (depth_mem[i]) depth_mem[i] = DEPTH_EMPTY;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tube_r    = 16'd256;
            ring_r    = 16'd512;
            scr_scale = 16'd20480;
            obj_off   = 16'd1280;
            rot_sd = 0; rot_cd = 0; rot_sa = 0; rot_ca = 0;
            clear_depth();
            pixel_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[3:2]))
                    REG_TUBE_RADIUS:   tube_r    = i_pwdata[LEN_W-1:0];
                    REG_RING_RADIUS:   ring_r    = i_pwdata[LEN_W-1:0];
                    REG_SCREEN_SCALE:  scr_scale = i_pwdata[LEN_W-1:0];
                    REG_OBJECT_OFFSET: obj_off   = i_pwdata[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (pixel_q.size() == 0) begin
                    report_mismatch("unexpected pixel", i_out_data.pixel_x, -1);
                end else begin
                    t_out_item want;
                    want = pixel_q.pop_front();
                    if (i_out_data.pixel_x !== want.pixel_x)
                        report_mismatch("pixel_x", i_out_data.pixel_x, want.pixel_x);
                    if (i_out_data.pixel_y !== want.pixel_y)
                        report_mismatch("pixel_y", i_out_data.pixel_y, want.pixel_y);
                    if (i_out_data.glyph !== want.glyph)
                        report_mismatch("glyph", i_out_data.glyph, want.glyph);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.op == OP_FRAME) begin
                    rot_sd = i_in_data.rot_sin_d;
                    rot_cd = i_in_data.rot_cos_d;
                    rot_sa = i_in_data.rot_sin_a;
                    rot_ca = i_in_data.rot_cos_a;
                    clear_depth();
                end else begin
                    shade_point(i_in_data);
                end
            end
        end
        o_pending = pixel_q.size();
    end

endmodule

>>> tb/torus_point_depth_shader_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Torus point depth shader testbench
// Drives frame and surface point transactions with random gaps and output
// stalls across several register settings; the checker predicts and compares.
// ----------------------------------------------------------------------------
module torus_point_depth_shader_tb;
    import tpds_pkg::*;

    localparam int DRAIN_CYCLES = 9000; // frame sweep plus queued points

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in_item    in_data = '0;
    logic        in_stall;
    logic        out_valid;
    t_out_item   out_data;
    logic        out_stall = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count, pending;
    bit          no_idle;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    torus_point_depth_shader u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_data(in_data), .o_in_stall(in_stall),
        .o_out_valid(out_valid), .o_out_data(out_data), .i_out_stall(out_stall),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    torus_point_depth_shader_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Hard stop: a slow but correct run ends well before this timeout.
    initial begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Output side: stall for a random count, then take one transaction.
    initial begin
        int w;
        @(posedge i_clk iff i_rst_n);
        forever begin
            w = no_idle ? 0 : $urandom_range(0, 5);
            if (w != 0) begin
                out_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
                out_stall <= 1'b0;
            end
            @(posedge i_clk);
            while (!out_valid) @(posedge i_clk);
        end
    end

    function automatic logic signed [15:0] q14(real v);
        return 16'(int'(v * 16384.0));
    endfunction

    // Hold valid low for a random gap, then hold the transaction until taken.
    task automatic send(t_in_item it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    task automatic send_frame(logic signed [15:0] sd, cd, sa, ca);
        t_in_item it;
        it = '0;
        it.op = OP_FRAME;
        it.rot_sin_d = sd; it.rot_cos_d = cd; it.rot_sin_a = sa; it.rot_cos_a = ca;
        it.pt_sin_psi = 16'($urandom); it.pt_cos_psi = 16'($urandom);  // ignored fields
        send(it);
    endtask

    task automatic send_point(logic signed [15:0] sp, cp, st, ct);
        t_in_item it;
        it = '0;
        it.op = OP_POINT;
        it.pt_sin_psi = sp; it.pt_cos_psi = cp; it.pt_sin_theta = st; it.pt_cos_theta = ct;
        it.rot_sin_d = 16'($urandom); it.rot_cos_a = 16'($urandom);    // ignored fields
        send(it);
    endtask

    // Frame from two random angles, point from two random angles.
    task automatic send_random_frame();
        real d, a;
        d = $urandom_range(0, 62831) / 10000.0;
        a = $urandom_range(0, 62831) / 10000.0;
        send_frame(q14($sin(d)), q14($cos(d)), q14($sin(a)), q14($cos(a)));
    endtask

    task automatic send_random_point();
        real p, t;
        p = $urandom_range(0, 62831) / 10000.0;
        t = $urandom_range(0, 62831) / 10000.0;
        send_point(q14($sin(p)), q14($cos(p)), q14($sin(t)), q14($cos(t)));
    endtask

    task automatic reg_write(t_reg_idx idx, logic [15:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'h0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Drain: drop valid, wait for every predicted pixel, let the back end settle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_cfg(logic [15:0] tube, ring, scr, off);
        reg_write(REG_TUBE_RADIUS, tube);
        reg_write(REG_RING_RADIUS, ring);
        reg_write(REG_SCREEN_SCALE, scr);
        reg_write(REG_OBJECT_OFFSET, off);
    endtask

    logic [15:0] cfg_tbl [6][4] = '{
        '{16'd0,     16'd0,     16'd65535, 16'd65535},
        '{16'd65535, 16'd65535, 16'd0,     16'd0},
        '{16'd128,   16'd768,   16'd30000, 16'd3000},
        '{16'd256,   16'd512,   16'd65535, 16'd600},
        '{16'd512,   16'd256,   16'd20480, 16'd0},
        '{16'd256,   16'd512,   16'd20480, 16'd1280}
    };

    initial begin
        no_idle = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: point before any frame sees zero rotation.
        send_point(16'sd0, 16'sd16384, 16'sd0, 16'sd16384);
        send_frame(16'sd0, 16'sd16384, 16'sd0, 16'sd16384);
        send_point(16'sd0, 16'sd16384, 16'sd0, 16'sd16384);
        send_point(16'sd0, 16'sd16384, 16'sd0, 16'sd16384);   // not nearer
        send_point(-16'sd16384, 16'sd0, 16'sd16384, 16'sd0);
        send_point(16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
        send_point(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_frame(-16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384);
        send_point(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
        send_point(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
        send_frame(16'sd11585, 16'sd11585, 16'sd11585, 16'sd11585);
        send_point(16'sd11585, -16'sd11585, 16'sd0, 16'sd16384);
        send_point(-16'sd11585, 16'sd11585, 16'sd16384, 16'sd0);
        // Raw trig beyond one is used as given.
        send_point(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
        send_frame(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
        send_point(16'sd0, 16'sh7FFF, 16'sd0, 16'sh8000);
        drain();

        // Random phases under each register setting; the third one runs without gaps or stalls.
        for (int ph = 0; ph < 6; ph++) begin
            apply_cfg(cfg_tbl[ph][0], cfg_tbl[ph][1], cfg_tbl[ph][2], cfg_tbl[ph][3]);
            no_idle = (ph == 2);
            send_random_frame();
            for (int n = 0; n < 140; n++) begin
                if ($urandom_range(0, 99) < 2) send_random_frame();
                else send_random_point();
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> torus_point_depth_shader.f
+incdir+rtl
rtl/tpds_pkg.sv
rtl/tpds_front.sv
rtl/tpds_div.sv
rtl/tpds_back.sv
rtl/torus_point_depth_shader.sv
tb/torus_point_depth_shader_checker.sv
tb/torus_point_depth_shader_tb.sv
